[src/mf3_pkg.sv]
package mf3_pkg;

    // window geometry: 3x3 taps, median is the middle of nine
    localparam int WIN_DIM  = 3;
    localparam int WIN_TAPS = 9;
    localparam int MED_TAP  = 4;

    // width of the side register write data
    localparam int CFG_BITS    = 11;
    localparam int SIDE_RESET  = 1024;
    localparam int SIDE_MIN    = 3;

    // stages between accept and the output queue
    localparam int PIPE_DEPTH = 4;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;
    localparam int OCC_W      = 5;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } t_win_ctl;

endpackage

[src/median_filter_3x3.sv]
// the result for a pixel leaves after the transfer of the item side_length+1 later
// throughput: one item per cycle while o_in_stall is low, set by the line store ram (one read, one write a cycle)
// an 8-entry output queue keeps input transfers going while the output is stalled
// reset (synchronous, active low) clears counters and pipeline, side_length to 1024;
// the line store is not cleared
module median_filter_3x3 #(
    parameter int MAX_SIDE    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_filtered,
    output logic                          o_last_pixel,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mf3_pkg::CFG_BITS-1:0]  i_cfg_data
);

    import mf3_pkg::*;

    logic                          w_acc;
    logic                          w_cfg_we;
    logic signed [SAMPLE_BITS-1:0] w_win [WIN_TAPS];
    t_win_ctl                      w_ctl;
    logic                          w_med_valid;
    logic signed [SAMPLE_BITS-1:0] w_med_data;
    logic                          w_med_last;

    logic [PIPE_DEPTH-1:0]         r_acc_dly;
    logic signed [SAMPLE_BITS-1:0] r_q_data [FIFO_DEPTH];
    logic                          r_q_last [FIFO_DEPTH];
    logic [FIFO_AW-1:0]            r_wp;
    logic [FIFO_AW-1:0]            r_rp;
    logic [FIFO_CW-1:0]            r_cnt;
    logic [OCC_W-1:0]              w_occ;
    logic                          w_pop;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;

    // queue entries plus every item still in the pipe, so nothing can overflow
    assign w_occ      = OCC_W'(r_cnt) + OCC_W'($countones(r_acc_dly));
    assign o_in_stall = w_occ >= OCC_W'(FIFO_DEPTH);
    assign w_acc      = i_in_valid && !o_in_stall;

    mf3_window #(
        .MAX_SIDE    (MAX_SIDE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (w_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_acc      (w_acc),
        .i_mode     (i_mode),
        .i_sample   (i_sample),
        .o_win      (w_win),
        .o_ctl      (w_ctl)
    );

    mf3_median #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (w_win),
        .i_ctl   (w_ctl),
        .o_valid (w_med_valid),
        .o_data  (w_med_data),
        .o_last  (w_med_last)
    );

    assign w_pop = (r_cnt != '0) && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_dly <= '0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
        end else begin
            r_acc_dly <= {r_acc_dly[PIPE_DEPTH-2:0], w_acc};
            if (w_med_valid) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            if (w_med_valid && !w_pop) begin
                r_cnt <= r_cnt + FIFO_CW'(1);
            end else if (!w_med_valid && w_pop) begin
                r_cnt <= r_cnt - FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_med_valid) begin
            r_q_data[r_wp] <= w_med_data;
            r_q_last[r_wp] <= w_med_last;
        end
    end

    assign o_out_valid  = r_cnt != '0;
    assign o_filtered   = r_q_data[r_rp];
    assign o_last_pixel = r_q_last[r_rp];

endmodule

[src/mf3_ram.sv]
module mf3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/mf3_window.sv]
module mf3_window #(
    parameter int MAX_SIDE    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mf3_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  logic                          i_acc,
    input  logic                          i_mode,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_win [mf3_pkg::WIN_TAPS],
    output mf3_pkg::t_win_ctl             o_ctl
);

    import mf3_pkg::*;

    localparam int CW   = $clog2(MAX_SIDE);
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int RW   = SW + 1;
    localparam int CMPW = (CFG_BITS > SW) ? CFG_BITS : SW;
    localparam int SIDE_RST = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
    localparam int SB   = SAMPLE_BITS;

    logic [SW-1:0] r_side;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic [CW-1:0]   w_col;
    logic [RW-1:0]   w_side_r;
    logic [RW-1:0]   w_pr;
    logic [RW-1:0]   w_pc;
    logic            w_emit;
    logic            w_interior;
    logic            w_last;
    logic            w_col_wrap;
    logic [CMPW-1:0] w_cfg_ext;
    logic [CMPW-1:0] w_side_sat;
    logic signed [SB-1:0] w_x;

    logic            r_s1_act;
    logic [CW-1:0]   r_s1_col;
    logic signed [SB-1:0] r_s1_x;
    t_win_ctl        r_s1_ctl;

    logic [2*SB-1:0] w_rdata;
    logic signed [SB-1:0] w_top;
    logic signed [SB-1:0] w_mid;

    logic signed [SB-1:0] r_win [WIN_TAPS];
    logic signed [SB-1:0] n_win [WIN_TAPS];
    t_win_ctl        r_ctl;

    // stage 0: position of the incoming item and what it emits
    always_comb begin
        w_col      = (SW'(r_col) >= r_side) ? '0 : r_col;
        w_side_r   = RW'(r_side);
        w_emit     = (r_row >= RW'(2)) || ((r_row == RW'(1)) && (w_col != '0));
        w_pr       = (w_col == '0) ? (r_row - RW'(2)) : (r_row - RW'(1));
        w_pc       = (w_col == '0) ? (w_side_r - RW'(1)) : (RW'(w_col) - RW'(1));
        w_interior = (w_pr != '0) && ((w_pr + RW'(2)) <= w_side_r)
                  && (w_pc != '0) && ((w_pc + RW'(2)) <= w_side_r);
        w_last     = ((w_pr + RW'(1)) == w_side_r) && ((w_pc + RW'(1)) == w_side_r);
        w_col_wrap = (RW'(w_col) + RW'(1)) >= w_side_r;
        w_x        = i_mode ? '0 : i_sample;
        w_cfg_ext  = CMPW'(i_cfg_data);
        if (w_cfg_ext < CMPW'(SIDE_MIN)) begin
            w_side_sat = CMPW'(SIDE_MIN);
        end else if (w_cfg_ext > CMPW'(MAX_SIDE)) begin
            w_side_sat = CMPW'(MAX_SIDE);
        end else begin
            w_side_sat = w_cfg_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SW'(SIDE_RST);
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_cfg_we) begin
            r_side <= w_side_sat[SW-1:0];
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_acc) begin
            if (w_emit && w_last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (w_col_wrap) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= w_col + CW'(1);
            end
        end
    end

    // each entry holds {upper, middle}; an entry is rewritten the cycle after
    // its read and read again no sooner than three items later, except for
    // column 0 right after the last pixel, where the older entry that is read
    // only reaches the rows above a new image and so only border pixels
    mf3_ram #(
        .WIDTH (2 * SB),
        .DEPTH (MAX_SIDE)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_s1_act),
        .i_waddr (r_s1_col),
        .i_wdata ({w_mid, r_s1_x}),
        .i_re    (i_acc),
        .i_raddr (w_col),
        .o_rdata (w_rdata)
    );

    assign w_top = w_rdata[2*SB-1:SB];
    assign w_mid = w_rdata[SB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_act <= 1'b0;
        end else begin
            r_s1_act <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_col <= w_col;
            r_s1_x   <= w_x;
            r_s1_ctl <= '{emit: w_emit, interior: w_interior, last: w_last};
        end
    end

    // stage 1: shift the window by one column
    always_comb begin
        for (int i = 0; i < WIN_DIM; i++) begin
            n_win[i*WIN_DIM]     = r_win[i*WIN_DIM + 1];
            n_win[i*WIN_DIM + 1] = r_win[i*WIN_DIM + 2];
        end
        n_win[2]           = w_top;
        n_win[WIN_DIM + 2] = w_mid;
        n_win[2*WIN_DIM+2] = r_s1_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_TAPS; k++) begin
                r_win[k] <= '0;
            end
            r_ctl <= '0;
        end else begin
            if (r_s1_act) begin
                r_win <= n_win;
            end
            r_ctl <= '{emit:     r_s1_act & r_s1_ctl.emit,
                       interior: r_s1_ctl.interior,
                       last:     r_s1_ctl.last};
        end
    end

    assign o_win = r_win;
    assign o_ctl = r_ctl;

endmodule

[src/mf3_median.sv]
module mf3_median #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [SAMPLE_BITS-1:0] i_win [mf3_pkg::WIN_TAPS],
    input  mf3_pkg::t_win_ctl             i_ctl,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_data,
    output logic                          o_last
);

    import mf3_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] t_vec [WIN_TAPS];

    // compare-exchange: smaller value ends at index a
    function automatic t_vec cx(t_vec v, int a, int b);
        t_vec r;
        r    = v;
        r[a] = (v[a] > v[b]) ? v[b] : v[a];
        r[b] = (v[a] > v[b]) ? v[a] : v[b];
        return r;
    endfunction

    t_vec     w_a;
    t_vec     w_b;
    t_vec     w_c;
    t_vec     r_a;
    t_vec     r_b;
    t_win_ctl r_a_ctl;
    t_win_ctl r_b_ctl;
    logic signed [SAMPLE_BITS-1:0] r_a_ctr;
    logic signed [SAMPLE_BITS-1:0] r_b_ctr;

    // 19-exchange median network split into combinational blocks, registered in r_a and r_b
    always_comb begin
        w_a = i_win;
        w_a = cx(w_a, 1, 2);
        w_a = cx(w_a, 4, 5);
        w_a = cx(w_a, 7, 8);
        w_a = cx(w_a, 0, 1);
        w_a = cx(w_a, 3, 4);
        w_a = cx(w_a, 6, 7);
        w_a = cx(w_a, 1, 2);
        w_a = cx(w_a, 4, 5);
        w_a = cx(w_a, 7, 8);
    end

    always_comb begin
        w_b = r_a;
        w_b = cx(w_b, 0, 3);
        w_b = cx(w_b, 5, 8);
        w_b = cx(w_b, 4, 7);
        w_b = cx(w_b, 3, 6);
        w_b = cx(w_b, 1, 4);
        w_b = cx(w_b, 2, 5);
        w_b = cx(w_b, 4, 7);
    end

    always_comb begin
        w_c = r_b;
        w_c = cx(w_c, 4, 2);
        w_c = cx(w_c, 6, 4);
        w_c = cx(w_c, 4, 2);
    end

    always_ff @(posedge i_clk) begin
        r_a     <= w_a;
        r_b     <= w_b;
        r_a_ctr <= i_win[MED_TAP];
        r_b_ctr <= r_a_ctr;
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
        end
    end

    assign o_valid = r_b_ctl.emit;
    assign o_data  = r_b_ctl.interior ? w_c[MED_TAP] : r_b_ctr;
    assign o_last  = r_b_ctl.last;

endmodule

[tb/sv/median_filter_3x3_tb.sv]
`timescale 1ns / 100ps

module median_filter_3x3_tb;
    import mf3_pkg::*;

    localparam int MAX_SIDE       = 1024;
    localparam int SAMPLE_W       = 16;
    localparam int RANDOM_ITEMS   = 150;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       last_pixel;
    } t_pixel;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_mode;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [SAMPLE_W-1:0] o_filtered;
    logic                       o_last_pixel;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_BITS-1:0]        i_cfg_data;

    // shadow of the filter state
    logic signed [SAMPLE_W-1:0] upper_line [MAX_SIDE];
    logic signed [SAMPLE_W-1:0] middle_line [MAX_SIDE];
    logic signed [SAMPLE_W-1:0] win [3][3];
    int unsigned                next_col;
    int unsigned                next_row;
    int unsigned                side_now;

    t_pixel      expected_pixels [$];
    t_pixel      oldest_pixel;
    int unsigned error_count;
    int unsigned items_sent;
    int unsigned pixels_checked;
    int unsigned images_done;
    int unsigned side_writes;
    int unsigned steady_left;
    int unsigned hold_request;
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned quiet_cycles;

    median_filter_3x3 #(
        .MAX_SIDE   (MAX_SIDE),
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_filtered  (o_filtered),
        .o_last_pixel(o_last_pixel),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return SAMPLE_W'($urandom_range(0, 65535));
        if (r < 7) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        // narrow range gives plenty of ties in the window
        return SAMPLE_W'($urandom_range(0, 6)) - 16'd3;
    endfunction

    function automatic void reset_predictor();
        int i;
        for (i = 0; i < MAX_SIDE; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
        next_col = 0;
        next_row = 0;
        side_now = SIDE_RESET;
    endfunction

    function automatic void apply_side(input int unsigned value);
        int unsigned v;
        v = value & 32'h7FF;
        if (v < SIDE_MIN) v = SIDE_MIN;
        if (v > MAX_SIDE) v = MAX_SIDE;
        side_now = v;
        next_col = 0;
        next_row = 0;
    endfunction

    // exact signed median: the tap with at most four below and more than four up to it
    function automatic logic signed [SAMPLE_W-1:0] window_median();
        logic signed [SAMPLE_W-1:0] t [9];
        int i, j, below, upto;
        for (i = 0; i < 9; i++) t[i] = win[i / 3][i % 3];
        for (i = 0; i < 9; i++) begin
            below = 0;
            upto  = 0;
            for (j = 0; j < 9; j++) begin
                if (t[j] < t[i]) below++;
                if (t[j] <= t[i]) upto++;
            end
            if (below <= 4 && upto > 4) return t[i];
        end
        return t[4];
    endfunction

    function automatic void predict_pixel(input logic flush, input logic signed [SAMPLE_W-1:0] smp);
        logic signed [SAMPLE_W-1:0] x, top, mid;
        int unsigned c, r, pr, pc;
        int i;
        bit interior;
        t_pixel p;
        x = flush ? '0 : smp;
        c = next_col;
        r = next_row;
        if (c >= side_now) c = 0;
        top = upper_line[c];
        mid = middle_line[c];
        upper_line[c]  = mid;
        middle_line[c] = x;
        for (i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = x;
        if (c + 1 >= side_now) begin
            next_col = 0;
            next_row = (r + 1) & 32'h7FF;
        end else begin
            next_col = c + 1;
            next_row = r;
        end
        if (!(r >= 2 || (r == 1 && c >= 1))) return;
        // output trails the input by one row and one pixel
        if (c == 0) begin
            pr = r - 2;
            pc = side_now - 1;
        end else begin
            pr = r - 1;
            pc = c - 1;
        end
        interior = pr >= 1 && pr + 2 <= side_now && pc >= 1 && pc + 2 <= side_now;
        p.filtered   = interior ? window_median() : win[1][1];
        p.last_pixel = (pr + 1 == side_now) && (pc + 1 == side_now);
        expected_pixels.push_back(p);
        if (p.last_pixel) begin
            next_col = 0;
            next_row = 0;
        end
    endfunction

    task automatic send_item(input logic flush, input logic signed [SAMPLE_W-1:0] value);
        int unsigned gap;
        if (steady_left != 0) begin
            gap = 0;
            steady_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 7) == 0) steady_left = $urandom_range(10, 60);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            i_sample   <= SAMPLE_W'($urandom_range(0, 65535));
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= flush;
        i_sample   <= value;
        do @(posedge i_clk); while (o_in_stall);
        predict_pixel(flush, value);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_side(input int unsigned value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CFG_BITS'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_side(value);
        side_writes++;
    endtask

    task automatic send_image(input int unsigned pushes);
        int unsigned k;
        for (k = 0; k < pushes; k++) send_item(1'b0, pick_sample());
    endtask

    // just past one full row at the reset side length, so the first pixels come out
    task automatic test_reset_side();
        send_image(MAX_SIDE + 4);
    endtask

    task automatic test_directed_images();
        logic signed [SAMPLE_W-1:0] pic [9];
        int i;
        write_side(0);
        pic = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                16'h7FFF, 16'h0100, 16'hFF00};
        for (i = 0; i < 9; i++) send_item(1'b0, pic[i]);
        for (i = 0; i < 4; i++) send_item(1'b1, 16'h5A5A);
        // flush in the centre inserts a zero; drain mixes samples and flushes
        write_side(2);
        pic = '{16'sd100, -16'sd100, 16'sd5, 16'sd7, 16'h7FFF, -16'sd7,
                16'h7FFF, 16'h8000, 16'sd3};
        for (i = 0; i < 9; i++) send_item(i == 4, pic[i]);
        send_item(1'b0, 16'sd1234);
        send_item(1'b1, 16'hFFFF);
        send_item(1'b0, -16'sd1);
        send_item(1'b1, 16'h0000);
    endtask

    task automatic test_side_clamp();
        int unsigned k;
        write_side(1);
        send_image(9);
        for (k = 0; k < 4; k++) send_item(1'b1, pick_sample());
    endtask

    task automatic test_restart_mid_image();
        int unsigned k;
        write_side(5);
        send_image(12);
        write_side(4);
        send_image(16);
        for (k = 0; k < 5; k++) send_item(1'b1, pick_sample());
    endtask

    task automatic test_backpressure();
        int unsigned k;
        write_side(8);
        hold_request = 300;
        send_image(64);
        for (k = 0; k < 9; k++) send_item(1'b1, pick_sample());
        write_side(8);
        send_image(30);
        wait_idle();
        send_image(34);
        for (k = 0; k < 9; k++) send_item(1'b1, pick_sample());
    endtask

    task automatic test_random_images();
        int unsigned first, side, pushes, k, r;
        bit clean;
        first = items_sent;
        clean = 1'b0;
        while (items_sent - first < RANDOM_ITEMS) begin
            if (!clean || $urandom_range(0, 2) != 0) begin
                r = $urandom_range(0, 99);
                side = r < 70 ? $urandom_range(3, 8) : $urandom_range(9, 16);
                write_side(side);
            end
            pushes = side_now * side_now;
            if ($urandom_range(0, 11) == 0) pushes = $urandom_range(1, pushes - 1);
            for (k = 0; k < pushes; k++) send_item($urandom_range(0, 24) == 0, pick_sample());
            clean = 1'b0;
            if (pushes == side_now * side_now) begin
                for (k = 0; k <= side_now; k++) send_item($urandom_range(0, 3) != 0, pick_sample());
                clean = 1'b1;
                // stray items start a new image that the next side write abandons
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 3)) send_item($urandom_range(0, 1), pick_sample());
                    clean = 1'b0;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (free_left != 0) begin
                free_left--;
            end else begin
                stall_left = pick_gap();
                free_left  = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(10, 60);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("output with nothing expected: filtered %0d last_pixel %0b",
                       o_filtered, o_last_pixel);
                error_count++;
            end else begin
                oldest_pixel = expected_pixels.pop_front();
                if (o_filtered !== oldest_pixel.filtered) begin
                    $error("filtered: expected %0d, actual %0d", oldest_pixel.filtered, o_filtered);
                    error_count++;
                end
                if (o_last_pixel !== oldest_pixel.last_pixel) begin
                    $error("last_pixel: expected %0b, actual %0b",
                           oldest_pixel.last_pixel, o_last_pixel);
                    error_count++;
                end
                if (oldest_pixel.last_pixel) images_done++;
                pixels_checked++;
            end
        end
    end

    // counts cycles without any transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles, %0d pixels still expected",
                   quiet_cycles, expected_pixels.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_mode       <= 1'b0;
        i_sample     <= '0;
        i_out_stall  <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= '0;
        error_count  = 0;
        items_sent   = 0;
        pixels_checked = 0;
        images_done  = 0;
        side_writes  = 0;
        steady_left  = 0;
        hold_request = 0;
        hold_left    = 0;
        stall_left   = 0;
        free_left    = 0;
        quiet_cycles = 0;
        reset_predictor();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_side();
        test_directed_images();
        test_side_clamp();
        test_restart_mid_image();
        test_backpressure();
        test_random_images();
        wait_idle();
        $display("run covered %0d items, %0d pixels checked, %0d whole images",
                 items_sent, pixels_checked, images_done);
        $display("%0d side writes, the reset side, small sides clamped up, flushes and restarts",
                 side_writes);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
